/* rtl/greedy_change_dispenser_assert.svh */
// ----------------------------------------------------------------------------
// Greedy change dispenser assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GREEDY_CHANGE_DISPENSER_ASSERT_SVH
`define GREEDY_CHANGE_DISPENSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gcdisp_pkg.sv */
// ----------------------------------------------------------------------------
// Greedy change dispenser package
// Denominations, reciprocal constants, status codes and shared types.
// ----------------------------------------------------------------------------
package gcdisp_pkg;

  localparam int unsigned NUM_DENOM   = 8;
  localparam int unsigned DENOM_IDX_W = 3;
  localparam int unsigned AMOUNT_W    = 16;
  localparam int unsigned LOAD_W      = 10;
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned PROD_W      = AMOUNT_W + RECIP_W;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 80;

  localparam logic [STATUS_W-1:0] STATUS_PAID   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Coin values in cents, smallest first.
  localparam logic [AMOUNT_W-1:0] DENOM_VALUE [NUM_DENOM] = '{
    16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd200, 16'd500, 16'd1000
  };

  // x / d == (x * RECIP) >> RECIP_SHIFT for every 16-bit x, with
  // RECIP = ceil(2^s / d) and s = 16 + ceil(log2 d).
  localparam logic [RECIP_W-1:0] RECIP [NUM_DENOM] = '{
    17'd104858, 17'd104858, 17'd104858, 17'd83887,
    17'd83887,  17'd83887,  17'd67109,  17'd67109
  };

  localparam logic [SHIFT_W-1:0] RECIP_SHIFT [NUM_DENOM] = '{
    5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26
  };

  typedef struct packed {
    logic                   accept;
    logic                   quot_en;
    logic                   take_en;
    logic                   finish;
    logic [DENOM_IDX_W-1:0] denom;
  } gcdisp_cmd_t;

endpackage

/* rtl/gcdisp_ctrl.sv */
// ----------------------------------------------------------------------------
// Greedy change dispenser controller
// Sequences the walk over the denominations and owns the output valid flag.
// ----------------------------------------------------------------------------
module gcdisp_ctrl import gcdisp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_kind_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output gcdisp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_QUOT = 2'd1;
  localparam logic [1:0] ST_TAKE = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [DENOM_IDX_W-1:0] denom_q, denom_d;
  logic                   out_valid_q, out_valid_d;
  logic                   accept;
  logic                   finish;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i & in_ready_o;
  // The result register is free once its current item has been taken.
  assign finish      = (state_q == ST_DONE) & (~out_valid_q | out_ready_i);

  assign cmd_o.accept  = accept;
  assign cmd_o.quot_en = (state_q == ST_QUOT);
  assign cmd_o.take_en = (state_q == ST_TAKE);
  assign cmd_o.finish  = finish;
  assign cmd_o.denom   = denom_q;

  always_comb begin
    state_d = state_q;
    denom_d = denom_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          denom_d = DENOM_IDX_W'(NUM_DENOM - 1);
          state_d = (in_kind_i == KIND_REQUEST) ? ST_QUOT : ST_DONE;
        end
      end
      ST_QUOT: begin
        state_d = ST_TAKE;
      end
      ST_TAKE: begin
        if (denom_q == '0) begin
          state_d = ST_DONE;
        end else begin
          denom_d = denom_q - 1'b1;
          state_d = ST_QUOT;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      denom_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      denom_q     <= denom_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/gcdisp_dp.sv */
// ----------------------------------------------------------------------------
// Greedy change dispenser datapath
// Coin stock, remainder, reciprocal divider step and the result register.
// ----------------------------------------------------------------------------
module gcdisp_dp import gcdisp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gcdisp_cmd_t            cmd_i,
  input  logic                   in_kind_i,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  output logic [STATUS_W-1:0]    res_status_o,
  output logic [OUT_TDATA_W-1:0] res_coins_o
);

  logic                   kind_q;
  logic [DENOM_IDX_W-1:0] idx_q;
  logic [LOAD_W-1:0]      value_q;
  logic [AMOUNT_W-1:0]    rest_q;
  logic [PROD_W-1:0]      prod_q;
  logic [COUNT_WIDTH-1:0] used_q  [NUM_DENOM];
  logic [COUNT_WIDTH-1:0] stock_q [NUM_DENOM];
  logic [STATUS_W-1:0]    status_q;
  logic [OUT_TDATA_W-1:0] coins_q;

  logic [PROD_W-1:0]      prod_d;
  logic [AMOUNT_W-1:0]    quot;
  logic [AMOUNT_W-1:0]    stock_ext;
  logic [AMOUNT_W-1:0]    take;
  logic [AMOUNT_W-1:0]    pay;
  logic [AMOUNT_W-1:0]    coin_ext [NUM_DENOM];
  logic [AMOUNT_W-1:0]    load_ext;
  logic [OUT_TDATA_W-1:0] coins_packed;
  logic                   paid;

  assign prod_d    = PROD_W'(rest_q) * PROD_W'(RECIP[cmd_i.denom]);
  assign quot      = AMOUNT_W'(prod_q >> RECIP_SHIFT[cmd_i.denom]);
  assign stock_ext = AMOUNT_W'(stock_q[cmd_i.denom]);
  assign take      = (quot < stock_ext) ? quot : stock_ext;
  // take never exceeds rest / value, so the product fits the remainder.
  assign pay       = AMOUNT_W'(take * DENOM_VALUE[cmd_i.denom]);
  assign load_ext  = AMOUNT_W'(value_q);
  assign paid      = (rest_q == '0);

  always_comb begin
    for (int i = 0; i < NUM_DENOM; i++) begin
      coin_ext[i] = AMOUNT_W'(used_q[i]);
    end
  end

  // Counts are cut to the width of their output field.
  assign coins_packed = {6'd0,
                         coin_ext[7][6:0], coin_ext[6][7:0], coin_ext[5][8:0],
                         coin_ext[4][9:0], coin_ext[3][9:0], coin_ext[2][9:0],
                         coin_ext[1][9:0], coin_ext[0][9:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= in_kind_i;
      idx_q   <= in_tdata_i[2:0];
      value_q <= in_tdata_i[12:3];
      rest_q  <= in_tdata_i[28:13];
    end else if (cmd_i.take_en) begin
      rest_q <= rest_q - pay;
    end
    if (cmd_i.quot_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.take_en) begin
      used_q[cmd_i.denom] <= take[COUNT_WIDTH-1:0];
    end
    if (cmd_i.finish) begin
      if (kind_q == KIND_LOAD) begin
        status_q <= STATUS_LOADED;
        coins_q  <= '0;
      end else if (paid) begin
        status_q <= STATUS_PAID;
        coins_q  <= coins_packed;
      end else begin
        status_q <= STATUS_SHORT;
        coins_q  <= '0;
      end
    end
  end

  // The stock only changes when an item finishes: a load overwrites one
  // count, a request that was paid exactly gives up the coins it used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DENOM; i++) begin
        stock_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      if (kind_q == KIND_LOAD) begin
        stock_q[idx_q] <= load_ext[COUNT_WIDTH-1:0];
      end else if (paid) begin
        for (int i = 0; i < NUM_DENOM; i++) begin
          stock_q[i] <= stock_q[i] - used_q[i];
        end
      end
    end
  end

  assign res_status_o = status_q;
  assign res_coins_o  = coins_q;

endmodule

/* rtl/greedy_change_dispenser.sv */
// ----------------------------------------------------------------------------
// Greedy change dispenser
// Keeps a coin stock for eight denominations and pays amounts out greedily.
// ----------------------------------------------------------------------------
// The slave channel takes one item at a time: tuser selects a stock load or
// a change request, tdata carries the denomination, the new count and the
// amount in cents. Every item gives exactly one item on the master channel,
// with the status in tuser and the coin counts per denomination in tdata.
// A load goes to the result step as soon as it is accepted. A request
// walks the eight denominations from the largest down, each with a step
// for the reciprocal multiply and a step to clamp to stock and update the
// remainder, and then goes to the result step. The block is ready for the
// next item once the result is registered, so it never takes a new item
// before it is through with the last one. The single result
// register lets the block accept a new item while the previous result is
// still waiting to be taken. If the receiver stalls, the finished item waits
// in its last step and the stock is not touched until the result register
// is free. Reset empties the stock and clears the output valid flag. A
// request that cannot be paid exactly reports the short status and leaves
// the stock as it was.
// ----------------------------------------------------------------------------
`include "greedy_change_dispenser_assert.svh"

module greedy_change_dispenser import gcdisp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // denom_index [2:0], stock_value [12:3], amount_cents [28:13], zero above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // coins_5 [9:0], coins_10 [19:10], coins_20 [29:20], coins_50 [39:30],
  // coins_100 [49:40], coins_200 [58:50], coins_500 [66:59],
  // coins_1000 [73:67], zero above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [STATUS_W-1:0]    m_axis_tuser_o
);

  gcdisp_cmd_t cmd;

  gcdisp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_kind_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  gcdisp_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_kind_i    (s_axis_tuser_i),
    .in_tdata_i   (s_axis_tdata_i),
    .res_status_o (m_axis_tuser_o),
    .res_coins_o  (m_axis_tdata_o)
  );

  `GCD_ASSERT_NOW(a_finish_into_free_slot, cmd.finish, !m_axis_tvalid_o || m_axis_tready_i, "result register overwritten before it was taken")
  `GCD_ASSERT_NEXT(a_request_not_instant, cmd.accept && (s_axis_tuser_i == KIND_REQUEST), !cmd.finish, "request finished without walking the denominations")
  `GCD_ASSERT_NOW(a_unpaid_no_coins, m_axis_tvalid_o && (m_axis_tuser_o != STATUS_PAID), m_axis_tdata_o == '0, "coins reported for an item that paid nothing")

endmodule

/* tb/tb_greedy_change_dispenser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy change dispenser testbench
// Sends stock loads and change requests through the stream ports and checks
// each payout against a greedy model of the coin stock, under varied idling.
// ----------------------------------------------------------------------------
module tb_greedy_change_dispenser;
  import gcdisp_pkg::*;

  localparam int unsigned COUNT_W        = 10;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned REPORT_MAX     = 10;
  localparam int unsigned PAD_LSB        = 74;
  localparam int unsigned COIN_CENTS [NUM_DENOM] = '{5, 10, 20, 50, 100, 200, 500, 1000};
  localparam int unsigned COIN_W [NUM_DENOM]     = '{10, 10, 10, 10, 10, 9, 8, 7};

  typedef struct packed {
    logic [STATUS_W-1:0]            status;
    logic [NUM_DENOM-1:0][15:0]     coins;
  } payout_t;

  // Holds the coin stock as the block should see it and the payouts still due.
  class coin_ledger;
    logic [COUNT_W-1:0] coins_held [NUM_DENOM];
    payout_t            payouts_due [$];
    int unsigned        mismatches;
    int unsigned        n_loads;
    int unsigned        n_paid;
    int unsigned        n_short;

    function new();
      foreach (coins_held[d]) coins_held[d] = '0;
      mismatches = 0;
      n_loads    = 0;
      n_paid     = 0;
      n_short    = 0;
    endfunction

    function int unsigned pending();
      return payouts_due.size();
    endfunction

    function void flag(string what, logic [15:0] exp_val, logic [15:0] act_val);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
    endfunction

    function void note_item(logic kind, logic [IN_TDATA_W-1:0] data);
      logic [DENOM_IDX_W-1:0] idx;
      logic [LOAD_W-1:0]      value;
      int unsigned            rest;
      int unsigned            want;
      int unsigned            take;
      int                     d;
      payout_t                p;
      idx   = data[DENOM_IDX_W-1:0];
      value = data[DENOM_IDX_W +: LOAD_W];
      rest  = 32'(data[DENOM_IDX_W+LOAD_W +: AMOUNT_W]);
      p     = '0;
      if (kind == KIND_LOAD) begin
        coins_held[idx] = value[COUNT_W-1:0];
        p.status = STATUS_LOADED;
        n_loads++;
      end else begin
        // Largest coin first, never more than the stock holds.
        for (d = NUM_DENOM - 1; d >= 0; d--) begin
          want = rest / COIN_CENTS[d];
          take = (want < 32'(coins_held[d])) ? want : 32'(coins_held[d]);
          p.coins[d] = 16'(take);
          rest -= take * COIN_CENTS[d];
        end
        if (rest != 0) begin
          // A remainder left over means the stock stays as it was.
          p = '0;
          p.status = STATUS_SHORT;
          n_short++;
        end else begin
          p.status = STATUS_PAID;
          for (d = 0; d < NUM_DENOM; d++) begin
            coins_held[d] -= p.coins[d][COUNT_W-1:0];
            p.coins[d] = p.coins[d] & ((16'd1 << COIN_W[d]) - 16'd1);
          end
          n_paid++;
        end
      end
      payouts_due.push_back(p);
    endfunction

    function void check_payout(logic [STATUS_W-1:0] status, logic [OUT_TDATA_W-1:0] data);
      payout_t           due;
      int unsigned       lsb;
      int                d;
      logic [15:0]       got;
      if (payouts_due.size() == 0) begin
        flag("unexpected item, status", 16'd0, 16'(status));
        return;
      end
      due = payouts_due.pop_front();
      if (status !== due.status) flag("status", 16'(due.status), 16'(status));
      lsb = 0;
      for (d = 0; d < NUM_DENOM; d++) begin
        got = 16'((data >> lsb) & ((80'd1 << COIN_W[d]) - 80'd1));
        if (got !== due.coins[d])
          flag($sformatf("coins_%0d", COIN_CENTS[d]), due.coins[d], got);
        lsb += COIN_W[d];
      end
      if (data[OUT_TDATA_W-1:PAD_LSB] !== '0)
        flag("tdata padding", 16'd0, 16'(data[OUT_TDATA_W-1:PAD_LSB]));
    endfunction
  endclass

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // denom_index [2:0], stock_value [12:3], amount_cents [28:13], zero above
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  // kind
  logic                   s_axis_tuser_i  = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // coins_5 [9:0], coins_10 [19:10], coins_20 [29:20], coins_50 [39:30],
  // coins_100 [49:40], coins_200 [58:50], coins_500 [66:59],
  // coins_1000 [73:67], zero above
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  // status
  logic [STATUS_W-1:0]    m_axis_tuser_o;

  coin_ledger  ledger = new();
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_hold_req  = 1'b0;

  greedy_change_dispenser #(
    .COUNT_WIDTH(COUNT_W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        ledger.check_payout(m_axis_tuser_o, m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o)
        ledger.note_item(s_axis_tuser_i, s_axis_tdata_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("No item moved for %0d cycles.", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // The receiver stalls at random, or holds off for a long stretch on request.
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic offer(input logic kind, input logic [DENOM_IDX_W-1:0] idx,
                       input logic [LOAD_W-1:0] value, input logic [AMOUNT_W-1:0] amount);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {{(IN_TDATA_W-DENOM_IDX_W-LOAD_W-AMOUNT_W){1'b0}}, amount, value, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Mostly requests that the current stock can plausibly pay, with loads
  // mixed in to refill it and some odd or huge amounts as noise.
  task automatic offer_random();
    int unsigned         pick;
    logic [LOAD_W-1:0]   value;
    logic [AMOUNT_W-1:0] amount;
    pick = $urandom_range(99);
    if (pick < 25) begin
      case ($urandom_range(2))
        0:       value = LOAD_W'($urandom_range(15));
        1:       value = LOAD_W'($urandom_range(120));
        default: value = LOAD_W'($urandom_range(1023));
      endcase
      offer(KIND_LOAD, DENOM_IDX_W'($urandom_range(NUM_DENOM - 1)), value,
            AMOUNT_W'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 45)      amount = AMOUNT_W'(5 * $urandom_range(100));
      else if (pick < 70) amount = AMOUNT_W'(5 * $urandom_range(1000));
      else if (pick < 82) amount = AMOUNT_W'(5 * $urandom_range(13107));
      else if (pick < 92) amount = AMOUNT_W'($urandom);
      else                amount = AMOUNT_W'($urandom_range(30));
      offer(KIND_REQUEST, DENOM_IDX_W'($urandom), LOAD_W'($urandom), amount);
    end
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned tx_pct,
                           input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n) offer_random();
  endtask

  // Lets the clock tick first, so that the item accepted at this edge is on the ledger.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty stock: a zero amount is still paid, anything else is refused.
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd0);
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd5);
    offer(KIND_LOAD, 3'd0, 10'd1023, 16'd0);
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd65535);
    for (int d = 1; d < NUM_DENOM; d++) offer(KIND_LOAD, 3'(d), 10'd1023, 16'd0);
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd65535);
    // Amounts that are not whole multiples of five cents.
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd3);
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd64);
    offer(KIND_LOAD, 3'd7, 10'd0, 16'd0);
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd1000);
    // Greedy takes the fifty and then gets stuck, although three twenties would do.
    offer(KIND_LOAD, 3'd1, 10'd0, 16'd0);
    offer(KIND_LOAD, 3'd0, 10'd0, 16'd0);
    offer(KIND_LOAD, 3'd2, 10'd3, 16'd0);
    offer(KIND_LOAD, 3'd3, 10'd1, 16'd0);
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd60);
    offer(KIND_REQUEST, 3'd0, 10'd0, 16'd40);

    run_phase(250, 0, 0);
    rx_hold_req = 1'b1;
    run_phase(30, 0, 0);
    settle();
    run_phase(200, 81, 0);
    run_phase(200, 0, 81);
    run_phase(200, 17, 17);
    run_phase(200, 0, 0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d stock loads, %0d payouts and %0d refused requests.",
             ledger.n_loads, ledger.n_paid, ledger.n_short);
    $display("Idling phases on both sides, plus a %0d-cycle receiver hold-off.", HOLD_CYCLES);
    if (ledger.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/gcdisp_pkg.sv
rtl/gcdisp_ctrl.sv
rtl/gcdisp_dp.sv
rtl/greedy_change_dispenser.sv
tb/tb_greedy_change_dispenser.sv
